// File: design/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked concurrent assertion, ignored while reset is high.
`define ASSERT_AT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Same, for a property that must also hold during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// File: design/crpe_pkg.sv
`timescale 1ns / 1ps
package crpe_pkg;

   localparam int MAX_ANCHORS = 16;
   localparam int T_FRAC_BITS = 16;

   localparam int T_W     = T_FRAC_BITS + 1;            // param_t / fraction width
   localparam int CNT_W   = 5;                          // anchor_count register width
   localparam int IDX_W   = 4;                          // anchor_index port width
   localparam int AIDX_W  = (MAX_ANCHORS > 1) ? $clog2(MAX_ANCHORS) : 1;
   localparam int COORD_W = 32;
   localparam int ACC_W   = 38;                         // Horner accumulator
   localparam int PROD_W  = ACC_W + T_W + 1;
   localparam int SC_W    = T_W + CNT_W;                // t * (n-1)

   localparam logic [T_W-1:0]   ONE       = T_W'(1) << T_FRAC_BITS;
   localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(4);
   localparam logic [CNT_W-1:0] CNT_MIN   = CNT_W'(4);

   // evaluation pipeline: accept -> s1 -> store read -> 8 Horner stages
   localparam int HORNER_STAGES = 8;
   localparam int LATENCY       = HORNER_STAGES + 2;

   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;
   localparam int REG_ANCHOR_COUNT = 0;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_EVAL  = 1'b1;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_FEW = 1'b1;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [ACC_W-1:0]   acc_type;
   typedef logic signed [PROD_W-1:0]  prod_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } anchor_type;

   typedef struct packed {
      logic              en;
      logic [AIDX_W-1:0] addr;
      anchor_type        data;
   } store_wr_type;

endpackage

// File: design/crpe_store.sv
`timescale 1ns / 1ps
module crpe_store (
   input  logic                                clock,
   input  crpe_pkg::store_wr_type              wr,
   input  logic [3:0][crpe_pkg::AIDX_W-1:0]    rd_addr,
   output crpe_pkg::anchor_type [3:0]          rd_data
);
   import crpe_pkg::*;

   // two identical banks, two read ports each
   anchor_type mem_a [MAX_ANCHORS];
   anchor_type mem_b [MAX_ANCHORS];
   anchor_type [3:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_a[wr.addr] <= wr.data;
         mem_b[wr.addr] <= wr.data;
      end
      rd_data_ff[0] <= mem_a[rd_addr[0]];
      rd_data_ff[1] <= mem_a[rd_addr[1]];
      rd_data_ff[2] <= mem_b[rd_addr[2]];
      rd_data_ff[3] <= mem_b[rd_addr[3]];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/crpe_horner.sv
`timescale 1ns / 1ps
module crpe_horner (
   input  logic                        clock,
   input  crpe_pkg::coord_type         p0,
   input  crpe_pkg::coord_type         p1,
   input  crpe_pkg::coord_type         p2,
   input  crpe_pkg::coord_type         p3,
   input  logic [crpe_pkg::T_W-1:0]    frac,
   output crpe_pkg::coord_type         point
);
   import crpe_pkg::*;

   localparam acc_type SAT_HI = acc_type'(32'sh7FFF_FFFF);
   localparam acc_type SAT_LO = acc_type'(32'sh8000_0000);

   acc_type e3_in, e2_in, e1_in, e0_in;
   acc_type e3_ff, e2_ff, e1_ff, e0_ff;
   logic [T_W-1:0] f3_ff, f4_ff, f5_ff, f6_ff, f7_ff;
   acc_type e2_4_ff, e1_4_ff, e1_5_ff, e1_6_ff;
   acc_type e0_4_ff, e0_5_ff, e0_6_ff, e0_7_ff, e0_8_ff;
   logic signed [T_W:0] f3_s, f5_s, f7_s;
   prod_type m1_in, m2_in, m3_in;
   prod_type m1_ff, m2_ff, m3_ff;
   acc_type a1_ff, a2_ff, a3_ff;
   acc_type half;
   coord_type point_in, point_ff;

   // integer coefficients
   always_comb begin
      e3_in = -acc_type'(p0) + 3 * acc_type'(p1) - 3 * acc_type'(p2) + acc_type'(p3);
      e2_in = 2 * acc_type'(p0) - 5 * acc_type'(p1) + 4 * acc_type'(p2) - acc_type'(p3);
      e1_in = acc_type'(p2) - acc_type'(p0);
      e0_in = 2 * acc_type'(p1);
   end

   assign f3_s  = signed'({1'b0, f3_ff});
   assign f5_s  = signed'({1'b0, f5_ff});
   assign f7_s  = signed'({1'b0, f7_ff});
   assign m1_in = e3_ff * f3_s;
   assign m2_in = a1_ff * f5_s;
   assign m3_in = a2_ff * f7_s;

   // round half up, then clamp to Q16.16
   always_comb begin
      half = (a3_ff + acc_type'(1)) >>> 1;
      if (half > SAT_HI) begin
         point_in = coord_type'(SAT_HI);
      end else if (half < SAT_LO) begin
         point_in = coord_type'(SAT_LO);
      end else begin
         point_in = coord_type'(half);
      end
   end

   always_ff @(posedge clock) begin
      e3_ff   <= e3_in;
      e2_ff   <= e2_in;
      e1_ff   <= e1_in;
      e0_ff   <= e0_in;
      f3_ff   <= frac;

      m1_ff   <= m1_in;
      e2_4_ff <= e2_ff;
      e1_4_ff <= e1_ff;
      e0_4_ff <= e0_ff;
      f4_ff   <= f3_ff;

      a1_ff   <= acc_type'(m1_ff >>> T_FRAC_BITS) + e2_4_ff;
      e1_5_ff <= e1_4_ff;
      e0_5_ff <= e0_4_ff;
      f5_ff   <= f4_ff;

      m2_ff   <= m2_in;
      e1_6_ff <= e1_5_ff;
      e0_6_ff <= e0_5_ff;
      f6_ff   <= f5_ff;

      a2_ff   <= acc_type'(m2_ff >>> T_FRAC_BITS) + e1_6_ff;
      e0_7_ff <= e0_6_ff;
      f7_ff   <= f6_ff;

      m3_ff   <= m3_in;
      e0_8_ff <= e0_7_ff;

      a3_ff   <= acc_type'(m3_ff >>> T_FRAC_BITS) + e0_8_ff;

      point_ff <= point_in;
   end

   assign point = point_ff;

endmodule

// File: design/catmull_rom_path_eval_unit.sv
`timescale 1ns / 1ps
// Channel   Ports                                         Transaction when
// request   start, busy, req_*                            start && !busy
// result    rsp_valid, rsp_point_x/y/z, rsp_status        rsp_valid (one cycle)
// csr       psel, penable, pwrite, paddr, pwdata, prdata  psel && penable && pwrite
//
// One transaction per cycle; busy is never raised.
// An evaluate result passes through one input stage, one anchor store read stage,
// and eight Horner stages (three multiplies).
// Anchor writes commit at the store read stage, so order is kept.
// Synchronous reset clears valid bits and sets anchor_count to 4; the anchor store
// itself is not cleared. Results cannot be stalled.
module catmull_rom_path_eval_unit (
   input  logic                              clock,
   input  logic                              reset,
   // request
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_type,
   input  logic [crpe_pkg::IDX_W-1:0]        req_anchor_index,
   input  crpe_pkg::coord_type               req_anchor_x,
   input  crpe_pkg::coord_type               req_anchor_y,
   input  crpe_pkg::coord_type               req_anchor_z,
   input  logic [crpe_pkg::T_FRAC_BITS:0]    req_param_t,
   // result
   output logic                              rsp_valid,
   output crpe_pkg::coord_type               rsp_point_x,
   output crpe_pkg::coord_type               rsp_point_y,
   output crpe_pkg::coord_type               rsp_point_z,
   output logic                              rsp_status,
   // csr
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [crpe_pkg::CSR_AW-1:0]       paddr,
   input  logic [crpe_pkg::CSR_DW-1:0]       pwdata,
   output logic [crpe_pkg::CSR_DW-1:0]       prdata,
   output logic                              pready
);
   import crpe_pkg::*;

   // ---------------- configuration ----------------
   logic [CNT_W-1:0] anchor_count_ff;
   logic             csr_hit;

   assign csr_hit = (paddr[CSR_AW-1:2] == (CSR_AW-2)'(REG_ANCHOR_COUNT));
   assign pready  = 1'b1;
   assign prdata  = csr_hit ? CSR_DW'(anchor_count_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         anchor_count_ff <= CNT_RESET;
      end else if (psel && penable && pwrite && pready && csr_hit) begin
         anchor_count_ff <= pwdata[CNT_W-1:0];
      end
   end

   // ---------------- stage 1: accepted transaction ----------------
   logic             accept;
   logic             s1_valid_ff;
   logic             s1_type_ff;
   logic [IDX_W-1:0] s1_index_ff;
   anchor_type       s1_anchor_ff;
   logic [T_W-1:0]   s1_t_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      s1_type_ff   <= req_type;
      s1_index_ff  <= req_anchor_index;
      s1_anchor_ff <= '{x: req_anchor_x, y: req_anchor_y, z: req_anchor_z};
      s1_t_ff      <= req_param_t;
   end

   // segment and fraction: clamp count and t, scale, pin t=1 to last segment
   logic [CNT_W-1:0]   n_eff;
   logic [T_W-1:0]     t_sat;
   logic [SC_W-1:0]    scaled;
   logic [CNT_W:0]     seg_raw;
   logic [CNT_W-1:0]   seg;
   logic [T_W-1:0]     frac_in;
   logic [CNT_W-1:0]   i0, i2, i3;
   logic               few_in;
   logic [3:0][AIDX_W-1:0] rd_addr;
   store_wr_type       wr;

   always_comb begin
      n_eff   = (anchor_count_ff > MAX_ANCHORS) ? CNT_W'(MAX_ANCHORS) : anchor_count_ff;
      few_in  = (anchor_count_ff < CNT_MIN);
      t_sat   = (s1_t_ff > ONE) ? ONE : s1_t_ff;
      scaled  = SC_W'(t_sat) * SC_W'(n_eff - CNT_W'(1));
      seg_raw = scaled[SC_W-1:T_FRAC_BITS];
      if (seg_raw > {1'b0, n_eff - CNT_W'(2)}) begin
         seg     = n_eff - CNT_W'(2);
         frac_in = ONE;
      end else begin
         seg     = seg_raw[CNT_W-1:0];
         frac_in = {1'b0, scaled[T_FRAC_BITS-1:0]};
      end
      // repeat the end anchors at the first and last segment
      i0 = (seg == '0) ? '0 : seg - CNT_W'(1);
      i2 = seg + CNT_W'(1);
      i3 = ((seg + CNT_W'(2)) >= n_eff) ? seg + CNT_W'(1) : seg + CNT_W'(2);
      rd_addr[0] = i0[AIDX_W-1:0];
      rd_addr[1] = seg[AIDX_W-1:0];
      rd_addr[2] = i2[AIDX_W-1:0];
      rd_addr[3] = i3[AIDX_W-1:0];
   end

   // anchor write commits at the same edge later evaluations read at
   always_comb begin
      wr.en   = s1_valid_ff && (s1_type_ff == REQ_WRITE)
                && (32'(s1_index_ff) < MAX_ANCHORS);
      wr.addr = AIDX_W'(s1_index_ff);
      wr.data = s1_anchor_ff;
   end

   // ---------------- stage 2: store read ----------------
   anchor_type [3:0] rd_data;
   logic             s2_valid_ff;
   logic             s2_few_ff;
   logic [T_W-1:0]   s2_frac_ff;

   crpe_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff && (s1_type_ff == REQ_EVAL);
      end
      s2_few_ff  <= few_in;
      s2_frac_ff <= frac_in;
   end

   // ---------------- stages 3..10: Horner per axis ----------------
   coord_type px, py, pz;

   crpe_horner u_horner_x (
      .clock (clock),
      .p0 (rd_data[0].x), .p1 (rd_data[1].x), .p2 (rd_data[2].x), .p3 (rd_data[3].x),
      .frac  (s2_frac_ff),
      .point (px)
   );

   crpe_horner u_horner_y (
      .clock (clock),
      .p0 (rd_data[0].y), .p1 (rd_data[1].y), .p2 (rd_data[2].y), .p3 (rd_data[3].y),
      .frac  (s2_frac_ff),
      .point (py)
   );

   crpe_horner u_horner_z (
      .clock (clock),
      .p0 (rd_data[0].z), .p1 (rd_data[1].z), .p2 (rd_data[2].z), .p3 (rd_data[3].z),
      .frac  (s2_frac_ff),
      .point (pz)
   );

   // valid and status ride alongside the Horner pipe
   logic [HORNER_STAGES-1:0] vpipe_ff;
   logic [HORNER_STAGES-1:0] fpipe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vpipe_ff <= '0;
      end else begin
         vpipe_ff <= {vpipe_ff[HORNER_STAGES-2:0], s2_valid_ff};
      end
      fpipe_ff <= {fpipe_ff[HORNER_STAGES-2:0], s2_few_ff};
   end

   assign rsp_valid   = vpipe_ff[HORNER_STAGES-1];
   assign rsp_status  = fpipe_ff[HORNER_STAGES-1] ? STATUS_FEW : STATUS_OK;
   // too few anchors: point reads as zero
   assign rsp_point_x = fpipe_ff[HORNER_STAGES-1] ? '0 : px;
   assign rsp_point_y = fpipe_ff[HORNER_STAGES-1] ? '0 : py;
   assign rsp_point_z = fpipe_ff[HORNER_STAGES-1] ? '0 : pz;

endmodule

// File: design/crpe_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module crpe_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           req_type,
   input logic                           rsp_valid,
   input crpe_pkg::coord_type            rsp_point_x,
   input crpe_pkg::coord_type            rsp_point_y,
   input crpe_pkg::coord_type            rsp_point_z,
   input logic                           rsp_status
);
   import crpe_pkg::*;

   `ASSERT_ALWAYS(a_never_busy, clock, !busy)
   `ASSERT_AT(a_eval_gives_result, clock, reset, (start && !busy && req_type == REQ_EVAL) |-> ##LATENCY rsp_valid)
   `ASSERT_AT(a_write_silent, clock, reset, (start && !busy && req_type == REQ_WRITE) |-> ##LATENCY !rsp_valid)
   `ASSERT_AT(a_result_has_cause, clock, reset, rsp_valid |-> $past(start && req_type == REQ_EVAL, LATENCY))
   `ASSERT_AT(a_few_is_zero, clock, reset, (rsp_valid && rsp_status == STATUS_FEW) |-> (rsp_point_x == 0 && rsp_point_y == 0 && rsp_point_z == 0))

endmodule

bind catmull_rom_path_eval_unit crpe_checker u_crpe_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_type    (req_type),
   .rsp_valid   (rsp_valid),
   .rsp_point_x (rsp_point_x),
   .rsp_point_y (rsp_point_y),
   .rsp_point_z (rsp_point_z),
   .rsp_status  (rsp_status)
);
